// ===== rtl/dcm_pkg.sv =====
// Shared types and constants for the DCM renormalization block.
// No dependencies; used by the front, the queue, the back and the top level.
package dcm_pkg;

  // depth of the word queue between the front and back pipelines
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // queue occupancy status seen by both pipelines
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/dcm_front.sv =====
// Front pipeline: orthogonality error, half-error correction of x and y, cross product z.
// Six register stages, held together on a full queue with stage six valid; uses dcm_pkg.
module dcm_front #(
  parameter int W = 16,
  parameter int F = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [W-1:0] x_i [3],
  input  logic signed [W-1:0] y_i [3],
  input  dcm_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output logic signed [W-1:0] xc_o [3],
  output logic signed [W-1:0] yc_o [3],
  output logic signed [W-1:0] zc_o [3]
);
  localparam int PW = 2 * W;
  localparam int SW = PW + 3;
  localparam logic signed [PW:0] RND_F = $signed({{PW{1'b0}}, 1'b1} << (F - 1));
  localparam logic signed [PW:0] RND_H = $signed({{PW{1'b0}}, 1'b1} << F);
  localparam logic signed [SW-1:0] SMAX = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW - W + 1){1'b1}}, {(W - 1){1'b0}}};

  // round half up, F fraction bits dropped
  function automatic logic signed [PW:0] rnd_f(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    t = $signed({p[PW-1], p}) + RND_F;
    return t >>> F;
  endfunction

  // same, with the extra halving shift
  function automatic logic signed [PW:0] rnd_h(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    t = $signed({p[PW-1], p}) + RND_H;
    return t >>> (F + 1);
  endfunction

  function automatic logic signed [W-1:0] sat_e(input logic signed [SW-1:0] v);
    logic signed [W-1:0] r;
    if (v > SMAX) r = SMAX[W-1:0];
    else if (v < SMIN) r = SMIN[W-1:0];
    else r = v[W-1:0];
    return r;
  endfunction

  logic [5:0] vld_q;
  logic       adv;

  logic signed [W-1:0]  s1_x_q [3], s1_y_q [3];
  logic signed [PW-1:0] s1_p_q [3];
  logic signed [W-1:0]  s2_x_q [3], s2_y_q [3];
  logic signed [W-1:0]  s2_e_q, s2_e_d;
  logic signed [W-1:0]  s3_x_q [3], s3_y_q [3];
  logic signed [PW-1:0] s3_px_q [3], s3_py_q [3];
  logic signed [W-1:0]  s4_xc_q [3], s4_yc_q [3], s4_xc_d [3], s4_yc_d [3];
  logic signed [W-1:0]  s5_xc_q [3], s5_yc_q [3];
  logic signed [PW-1:0] s5_c_q [3], s5_d_q [3];
  logic signed [W-1:0]  s6_xc_q [3], s6_yc_q [3], s6_zc_q [3], s6_zc_d [3];

  assign adv        = !vld_q[5] || !q_status_i.full;
  assign in_ready_o = adv;
  assign push_o     = vld_q[5] && !q_status_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  always_comb begin
    s2_e_d = sat_e(SW'(rnd_f(s1_p_q[0])) + SW'(rnd_f(s1_p_q[1])) + SW'(rnd_f(s1_p_q[2])));
    for (int i = 0; i < 3; i++) begin
      s4_xc_d[i] = sat_e(SW'(s3_x_q[i]) - SW'(rnd_h(s3_px_q[i])));
      s4_yc_d[i] = sat_e(SW'(s3_y_q[i]) - SW'(rnd_h(s3_py_q[i])));
      s6_zc_d[i] = sat_e(SW'(rnd_f(s5_c_q[i])) - SW'(rnd_f(s5_d_q[i])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_x_q[i]  <= x_i[i];
        s1_y_q[i]  <= y_i[i];
        s1_p_q[i]  <= x_i[i] * y_i[i];
        s2_x_q[i]  <= s1_x_q[i];
        s2_y_q[i]  <= s1_y_q[i];
        s3_x_q[i]  <= s2_x_q[i];
        s3_y_q[i]  <= s2_y_q[i];
        s3_px_q[i] <= s2_e_q * s2_y_q[i];
        s3_py_q[i] <= s2_e_q * s2_x_q[i];
        s4_xc_q[i] <= s4_xc_d[i];
        s4_yc_q[i] <= s4_yc_d[i];
        s5_xc_q[i] <= s4_xc_q[i];
        s5_yc_q[i] <= s4_yc_q[i];
        s6_xc_q[i] <= s5_xc_q[i];
        s6_yc_q[i] <= s5_yc_q[i];
        s6_zc_q[i] <= s6_zc_d[i];
      end
      s2_e_q    <= s2_e_d;
      // cross product terms, cyclic indices
      s5_c_q[0] <= s4_xc_q[1] * s4_yc_q[2];
      s5_d_q[0] <= s4_xc_q[2] * s4_yc_q[1];
      s5_c_q[1] <= s4_xc_q[2] * s4_yc_q[0];
      s5_d_q[1] <= s4_xc_q[0] * s4_yc_q[2];
      s5_c_q[2] <= s4_xc_q[0] * s4_yc_q[1];
      s5_d_q[2] <= s4_xc_q[1] * s4_yc_q[0];
    end
  end

  assign xc_o = s6_xc_q;
  assign yc_o = s6_yc_q;
  assign zc_o = s6_zc_q;

endmodule

// ===== rtl/dcm_queue.sv =====
// Short register queue decoupling the front and back pipelines.
// Depends on dcm_pkg for depth and status type.
module dcm_queue #(
  parameter int DW = 144
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [DW-1:0]      data_i,
  input  logic               pop_i,
  output logic [DW-1:0]      data_o,
  output dcm_pkg::q_status_t status_o
);
  import dcm_pkg::*;

  logic [DW-1:0]     mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign status_o.full  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign data_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("queue pop while empty");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("queue count slip");

endmodule

// ===== rtl/dcm_lane.sv =====
// One normalization lane: squared length, pipelined integer square root,
// pipelined restoring divide per element, saturation. No package use.
module dcm_lane #(
  parameter int W = 16,
  parameter int F = 14
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] v_i [3],
  output logic signed [W-1:0] o_o [3],
  output logic                deg_o
);
  localparam int PW = 2 * W;
  localparam int NW = W + F + 1;
  localparam logic [NW-1:0] QLIM_N = {{(NW - 1){1'b0}}, 1'b1} << (W - 1);
  localparam logic [NW-1:0] QLIM_P = QLIM_N - 1'b1;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

  logic signed [W-1:0] a_v_q [3];
  logic [PW-1:0]       a_sq_q [3];

  logic [PW-1:0]       s_rem_q  [W+1];
  logic [W-1:0]        s_root_q [W+1];
  logic signed [W-1:0] s_v_q    [W+1][3];
  logic                s_deg_q  [W+1];

  logic [W-1:0]  d_rem_q [NW+1][3];
  logic [NW-1:0] d_quo_q [NW+1][3];
  logic [NW-1:0] d_num_q [NW+1][3];
  logic          d_neg_q [NW+1][3];
  logic [W-1:0]  d_len_q [NW+1];
  logic          d_deg_q [NW+1];

  logic signed [W-1:0] o_d [3];
  logic [W-1:0]        mag [3];

  // squares and sum of squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a_v_q[i]  <= v_i[i];
        a_sq_q[i] <= PW'(v_i[i] * v_i[i]);
        s_v_q[0][i] <= a_v_q[i];
      end
      s_rem_q[0]  <= a_sq_q[0] + a_sq_q[1] + a_sq_q[2];
      s_root_q[0] <= '0;
      s_deg_q[0]  <= (a_sq_q[0] + a_sq_q[1] + a_sq_q[2]) == '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < W; k++) begin : g_sqrt
    localparam int B = W - 1 - k;
    logic [PW:0] trial;
    logic        take;
    assign trial = ((PW + 1)'(s_root_q[k]) << (B + 1)) + ((PW + 1)'(1) << (2 * B));
    assign take  = {1'b0, s_rem_q[k]} >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_rem_q[k+1]  <= take ? s_rem_q[k] - trial[PW-1:0] : s_rem_q[k];
        s_root_q[k+1] <= take ? (s_root_q[k] | (W'(1) << B)) : s_root_q[k];
        s_deg_q[k+1]  <= s_deg_q[k];
        for (int i = 0; i < 3; i++) s_v_q[k+1][i] <= s_v_q[k][i];
      end
    end
  end

  // divide setup: numerator |v| * 2^F + floor(L/2)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = s_v_q[W][i][W-1] ? W'(~s_v_q[W][i] + 1'b1) : W'(s_v_q[W][i]);
      d_num_q[0][i] = (NW'(mag[i]) << F) + NW'(s_root_q[W] >> 1);
      d_rem_q[0][i] = '0;
      d_quo_q[0][i] = '0;
      d_neg_q[0][i] = s_v_q[W][i][W-1];
    end
    d_len_q[0] = s_root_q[W];
    d_deg_q[0] = s_deg_q[W];
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < NW; j++) begin : g_div
    localparam int NB = NW - 1 - j;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_len_q[j+1] <= d_len_q[j];
        d_deg_q[j+1] <= d_deg_q[j];
      end
    end
    for (genvar i = 0; i < 3; i++) begin : g_el
      logic [W:0] tr;
      logic       ge;
      assign tr = {d_rem_q[j][i], d_num_q[j][i][NB]};
      assign ge = tr >= {1'b0, d_len_q[j]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          d_rem_q[j+1][i] <= ge ? W'(tr - {1'b0, d_len_q[j]}) : tr[W-1:0];
          d_quo_q[j+1][i] <= {d_quo_q[j][i][NW-2:0], ge};
          d_num_q[j+1][i] <= d_num_q[j][i];
          d_neg_q[j+1][i] <= d_neg_q[j][i];
        end
      end
    end
  end

  // sign and saturation; zero length forces zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d_deg_q[NW]) begin
        o_d[i] = '0;
      end else if (d_neg_q[NW][i]) begin
        o_d[i] = (d_quo_q[NW][i] > QLIM_N) ? MINV
                                           : $signed((~d_quo_q[NW][i][W-1:0]) + W'(1));
      end else begin
        o_d[i] = (d_quo_q[NW][i] > QLIM_P) ? MAXV : $signed(d_quo_q[NW][i][W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_o   <= o_d;
      deg_o <= d_deg_q[NW];
    end
  end

endmodule

// ===== rtl/dcm_back.sv =====
// Back pipeline: three normalization lanes in lock step plus the output register.
// Depends on dcm_lane and dcm_pkg.
module dcm_back #(
  parameter int W = 16,
  parameter int F = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dcm_pkg::q_status_t  q_status_i,
  output logic                pop_o,
  input  logic signed [W-1:0] xc_i [3],
  input  logic signed [W-1:0] yc_i [3],
  input  logic signed [W-1:0] zc_i [3],
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [W-1:0] xo_o [3],
  output logic signed [W-1:0] yo_o [3],
  output logic signed [W-1:0] zo_o [3],
  output logic                deg_o
);
  // squares, sum, W root stages, W+F+1 divide stages, output
  localparam int LAT = 2 * W + F + 4;

  logic [LAT-1:0] vld_q;
  logic           adv;
  logic           deg_x, deg_y, deg_z;

  assign adv         = !vld_q[LAT-1] || out_ready_i;
  assign pop_o       = adv && !q_status_i.empty;
  assign out_valid_o = vld_q[LAT-1];
  assign deg_o       = deg_x | deg_y | deg_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], !q_status_i.empty};
    end
  end

  dcm_lane #(.W(W), .F(F)) u_lane_x (
    .clk_i(clk_i), .en_i(adv), .v_i(xc_i), .o_o(xo_o), .deg_o(deg_x)
  );
  dcm_lane #(.W(W), .F(F)) u_lane_y (
    .clk_i(clk_i), .en_i(adv), .v_i(yc_i), .o_o(yo_o), .deg_o(deg_y)
  );
  dcm_lane #(.W(W), .F(F)) u_lane_z (
    .clk_i(clk_i), .en_i(adv), .v_i(zc_i), .o_o(zo_o), .deg_o(deg_z)
  );

endmodule

// ===== rtl/dcm_renormalize_top.sv =====
// Path: 6 front stages, the queue register, then the back pipeline of squares, sum,
//   one square-root stage per result bit, one divide stage per quotient bit, output.
// Throughput: one word per cycle while m_axis_tready is high; every stage is its own
//   register, nothing iterates.
// Reset: rst_ni, async active low; clears valid flags, queue pointers and count only.
module dcm_renormalize_top #(
  parameter int ELEM_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  // slave side
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_col_0, x_col_1, x_col_2, y_col_0, y_col_1, y_col_2 (lowest first)
  input  logic [((6 * ELEM_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // master side
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // x_out_0..2, y_out_0..2, z_out_0..2 (lowest first)
  output logic [((9 * ELEM_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // degenerate
  output logic                                  m_axis_tuser
);
  localparam int W      = ELEM_WIDTH;
  localparam int OUT_DW = ((9 * W + 7) / 8) * 8;
  localparam int QW     = 9 * W;

  logic signed [W-1:0] x_in [3], y_in [3];
  logic signed [W-1:0] f_xc [3], f_yc [3], f_zc [3];
  logic signed [W-1:0] b_xc [3], b_yc [3], b_zc [3];
  logic signed [W-1:0] xo [3], yo [3], zo [3];
  logic [QW-1:0]       q_wdata, q_rdata;
  logic [QW-1:0]       out_flat;
  logic                push, pop;
  dcm_pkg::q_status_t  q_status;

  // unpack the input word and repack the queue and output words
  for (genvar i = 0; i < 3; i++) begin : g_pack
    assign x_in[i] = $signed(s_axis_tdata[i*W +: W]);
    assign y_in[i] = $signed(s_axis_tdata[(3 + i)*W +: W]);

    assign q_wdata[i*W +: W]       = f_xc[i];
    assign q_wdata[(3 + i)*W +: W] = f_yc[i];
    assign q_wdata[(6 + i)*W +: W] = f_zc[i];

    assign b_xc[i] = $signed(q_rdata[i*W +: W]);
    assign b_yc[i] = $signed(q_rdata[(3 + i)*W +: W]);
    assign b_zc[i] = $signed(q_rdata[(6 + i)*W +: W]);

    assign out_flat[i*W +: W]       = xo[i];
    assign out_flat[(3 + i)*W +: W] = yo[i];
    assign out_flat[(6 + i)*W +: W] = zo[i];
  end

  assign m_axis_tdata = OUT_DW'(out_flat);

  // error, correction and cross product
  dcm_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .x_i        (x_in),
    .y_i        (y_in),
    .q_status_i (q_status),
    .push_o     (push),
    .xc_o       (f_xc),
    .yc_o       (f_yc),
    .zc_o       (f_zc)
  );

  // decoupling queue of corrected columns
  dcm_queue #(.DW(QW)) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (q_wdata),
    .pop_i    (pop),
    .data_o   (q_rdata),
    .status_o (q_status)
  );

  // per-column normalization
  dcm_back #(.W(W), .F(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .xc_i        (b_xc),
    .yc_i        (b_yc),
    .zc_i        (b_zc),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .xo_o        (xo),
    .yo_o        (yo),
    .zo_o        (zo),
    .deg_o       (m_axis_tuser)
  );

endmodule

// ===== sim/tb.sv =====
// Testbench for dcm_renormalize_top: streams matrices, predicts results in-bench.
// Depends on rtl/dcm_renormalize_top.sv (and dcm_pkg.sv through it).
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW = 16;
  localparam int FB = 14;
  localparam int IN_W  = ((6 * EW + 7) / 8) * 8;
  localparam int OUT_W = ((9 * EW + 7) / 8) * 8;
  localparam int LATENCY = 2 * EW + FB + 10;
  localparam int N_RANDOM = 900;

  typedef struct packed {
    logic [OUT_W-1:0] elems;
    logic             degenerate;
  } dcm_result_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  dcm_renormalize_top #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  logic [IN_W-1:0] pending_words[$];
  dcm_result_t     expected_results[$];
  int              n_errors = 0;
  bit              stim_done = 0;
  int              hold_off = 0;   // long receiver stall, counted down by the monitor
  bit              long_stall_done = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // ---- predictor ----
  function automatic longint sat_elem(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (EW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round half up: floor((p + 2^(s-1)) / 2^s)
  function automatic longint rnd_shift(longint p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] sq);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (sq >= root + bitv) begin
        sq   = sq - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // scale one vector to unit length; returns 1 on zero length
  function automatic bit unit_scale(ref longint v[3]);
    logic [63:0] sq, len, m, q;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m  = (v[i] < 0) ? -v[i] : v[i];
      sq = sq + m * m;
    end
    if (sq == 0) begin
      foreach (v[i]) v[i] = 0;
      return 1;
    end
    len = isqrt64(sq);
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      q = ((m << FB) + (len >> 1)) / len;
      v[i] = sat_elem((v[i] < 0) ? -longint'(q) : longint'(q));
    end
    return 0;
  endfunction

  function automatic dcm_result_t renormalize(logic [IN_W-1:0] w);
    longint x[3], y[3], xc[3], yc[3], zc[3];
    longint err;
    bit degen;
    dcm_result_t r;
    err = 0;
    for (int i = 0; i < 3; i++) begin
      x[i] = longint'($signed(w[i*EW +: EW]));
      y[i] = longint'($signed(w[(3+i)*EW +: EW]));
    end
    for (int i = 0; i < 3; i++) err += rnd_shift(x[i] * y[i], FB);
    err = sat_elem(err);
    for (int i = 0; i < 3; i++) begin
      xc[i] = sat_elem(x[i] - rnd_shift(err * y[i], FB + 1));
      yc[i] = sat_elem(y[i] - rnd_shift(err * x[i], FB + 1));
    end
    for (int i = 0; i < 3; i++)
      zc[i] = sat_elem(rnd_shift(xc[(i+1)%3] * yc[(i+2)%3], FB) -
                       rnd_shift(xc[(i+2)%3] * yc[(i+1)%3], FB));
    degen = unit_scale(xc);
    degen = unit_scale(yc) | degen;
    degen = unit_scale(zc) | degen;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      r.elems[i*EW +: EW]     = xc[i][EW-1:0];
      r.elems[(3+i)*EW +: EW] = yc[i][EW-1:0];
      r.elems[(6+i)*EW +: EW] = zc[i][EW-1:0];
    end
    r.degenerate = degen;
    return r;
  endfunction

  // ---- stimulus helpers ----
  function automatic logic [EW-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(EW-1){1'b0}}};
      1:       return {1'b0, {(EW-1){1'b1}}};
      2:       return '0;
      3, 4:    return EW'($urandom);
      default: return EW'($signed($urandom_range(0, 2 << FB)) - (1 << FB));
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_mat(logic [EW-1:0] e[6]);
    logic [IN_W-1:0] w;
    w = '0;
    for (int i = 0; i < 6; i++) w[i*EW +: EW] = e[i];
    return w;
  endfunction

  // near-orthonormal matrix: identity axes permuted with signs plus small noise
  function automatic logic [IN_W-1:0] near_rotation();
    logic [EW-1:0] e[6];
    int ax, ay, sx, sy, noise;
    ax = $urandom_range(0, 2);
    ay = (ax + $urandom_range(1, 2)) % 3;
    noise = $urandom_range(0, 1) ? 64 : 2048;
    for (int i = 0; i < 6; i++) e[i] = EW'($signed($urandom_range(0, 2*noise)) - noise);
    sx = $urandom_range(0, 1) ? 1 : -1;
    sy = $urandom_range(0, 1) ? 1 : -1;
    e[ax]   = e[ax] + EW'(sx * (1 << FB));
    e[3+ay] = e[3+ay] + EW'(sy * (1 << FB));
    return pack_mat(e);
  endfunction

  initial begin
    logic [EW-1:0] e[6];
    logic [EW-1:0] specials[5];
    specials = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hffff};
    // directed: identity, zero (every vector degenerate), parallel columns
    // (cross product zero), full-scale extremes, one zero column, one-LSB columns
    e = '{16'h4000, 0, 0, 0, 16'h4000, 0};      pending_words.push_back(pack_mat(e));
    e = '{0, 0, 0, 0, 0, 0};                   pending_words.push_back(pack_mat(e));
    e = '{16'h4000, 0, 0, 16'h4000, 0, 0};      pending_words.push_back(pack_mat(e));
    e = '{16'h2000, 16'h1000, 0, 16'h2000, 16'h1000, 0}; pending_words.push_back(pack_mat(e));
    e = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    pending_words.push_back(pack_mat(e));
    e = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    pending_words.push_back(pack_mat(e));
    e = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
    pending_words.push_back(pack_mat(e));
    e = '{0, 0, 0, 16'h4000, 16'h0001, 16'hffff}; pending_words.push_back(pack_mat(e));
    e = '{16'h0001, 0, 0, 0, 16'hffff, 0};      pending_words.push_back(pack_mat(e));
    for (int k = 0; k < 10; k++) begin
      foreach (e[i]) e[i] = specials[$urandom_range(0, 4)];
      pending_words.push_back(pack_mat(e));
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 9) < 7) pending_words.push_back(near_rotation());
      else begin
        foreach (e[i]) e[i] = rand_elem();
        pending_words.push_back(pack_mat(e));
      end
    end
    stim_done = 1;
  end

  // ---- driver ----
  int gap_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_cnt       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(renormalize(s_axis_tdata));
        void'(pending_words.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the word
      end else if (gap_cnt > 0) begin
        gap_cnt       <= gap_cnt - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        // queue head moved if a word was taken this edge
        if (pending_words.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_words[0];
          gap_cnt <= ($urandom_range(0, 3) != 0) ? 0 :
                     ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3));
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor and checker ----
  always @(posedge clk_i or negedge rst_ni) begin
    dcm_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_off      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_axis_tdata[i*EW +: EW] !== want.elems[i*EW +: EW]) begin
              $error("%s_out_%0d: expected %0d, got %0d",
                     (i < 3) ? "x" : (i < 6) ? "y" : "z", i % 3,
                     $signed(want.elems[i*EW +: EW]), $signed(m_axis_tdata[i*EW +: EW]));
              n_errors++;
            end
          if (m_axis_tuser !== want.degenerate) begin
            $error("degenerate: expected %0b, got %0b", want.degenerate, m_axis_tuser);
            n_errors++;
          end
        end
      end
      // long stall once the pipe is busy, so the input side backs up; rare random ones too
      if (hold_off > 0) begin
        hold_off      <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 999) == 0 ||
                   (!long_stall_done && expected_results.size() >= 30)) begin
        hold_off        <= 200;
        long_stall_done <= 1'b1;
        m_axis_tready   <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0) ||
                         ($urandom_range(0, 1) == 0 && $urandom_range(0, 9) != 0);
      end
    end
  end

  // ---- reset, end of run ----
  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stim_done && pending_words.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
